[rtl/core/ufc_pkg.sv]
// ufc_pkg: shared types, character constants and helper functions
// for the form url codec; no dependencies

package ufc_pkg;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam logic [1:0] MAX_RES = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2,
        PH_HALT  = 2'd3
    } phase_t;

    // one result request
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       run_last;
        logic       string_end;
        logic       bad_escape;
    } res_t;

    // everything one input request produces
    typedef struct packed {
        logic [1:0]      cnt;
        res_t [2:0]      res;
    } step_out_t;

    function automatic res_t mk_res(input logic [7:0] b, input logic has, input logic bad);
        res_t r;
        r.out_byte   = b;
        r.has_byte   = has;
        r.run_last   = 1'b0;
        r.string_end = 1'b0;
        r.bad_escape = bad;
        return r;
    endfunction

    // {ok, value} of a hex digit in either case
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            r = {1'b1, c[3:0]};
        end
        else if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    // upper-case hex character of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10)
        begin
            r = {4'h0, nib} + 8'h30;
        end
        else
        begin
            r = {4'h0, nib} + 8'h37;
        end
        return r;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

endpackage

[rtl/core/ufc_in_if.sv]
// ufc_in_if: input channel of the form url codec (valid/ready + payload)
// no dependencies

interface ufc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

[rtl/core/ufc_out_if.sv]
// ufc_out_if: result channel of the form url codec (valid/ready + payload)
// no dependencies

interface ufc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       string_end;
    logic       bad_escape;

    modport source (output valid, output out_byte, output has_byte, output run_last,
                    output string_end, output bad_escape, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input run_last,
                    input string_end, input bad_escape, output ready);
endinterface

[rtl/core/ufc_step.sv]
// ufc_step: direction register, decode state and per-request result logic
// depends on ufc_pkg

module ufc_step (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    input  logic                 cfg_we,
    input  logic                 cfg_data,
    output ufc_pkg::step_out_t   step_out
);

    logic              dir_reg;
    ufc_pkg::phase_t   phase_reg, phase_next;
    logic [3:0]        nib_reg, nib_next;
    logic [4:0]        hv;
    logic              se;

    always_comb
    begin
        hv         = ufc_pkg::hex_val(in_byte);
        phase_next = phase_reg;
        nib_next   = nib_reg;
        se         = in_last;
        step_out   = '0;

        if (dir_reg == ufc_pkg::DIR_ENCODE)
        begin
            if (ufc_pkg::is_alnum(in_byte))
            begin
                step_out.cnt    = 2'd1;
                step_out.res[0] = ufc_pkg::mk_res(in_byte, 1'b1, 1'b0);
            end
            else if (in_byte == ufc_pkg::CH_SPACE)
            begin
                step_out.cnt    = 2'd1;
                step_out.res[0] = ufc_pkg::mk_res(ufc_pkg::CH_PLUS, 1'b1, 1'b0);
            end
            else
            begin
                step_out.cnt    = ufc_pkg::MAX_RES;
                step_out.res[0] = ufc_pkg::mk_res(ufc_pkg::CH_PERCENT, 1'b1, 1'b0);
                step_out.res[1] = ufc_pkg::mk_res(ufc_pkg::hex_char(in_byte[7:4]), 1'b1, 1'b0);
                step_out.res[2] = ufc_pkg::mk_res(ufc_pkg::hex_char(in_byte[3:0]), 1'b1, 1'b0);
            end
        end
        else
        begin
            case (phase_reg)
                ufc_pkg::PH_IDLE:
                begin
                    if (in_byte == ufc_pkg::CH_PLUS)
                    begin
                        step_out.cnt    = 2'd1;
                        step_out.res[0] = ufc_pkg::mk_res(ufc_pkg::CH_SPACE, 1'b1, 1'b0);
                    end
                    else if (in_byte == ufc_pkg::CH_PERCENT)
                    begin
                        if (in_last)
                        begin
                            step_out.cnt    = 2'd1;
                            step_out.res[0] = ufc_pkg::mk_res(8'h00, 1'b0, 1'b1);
                        end
                        else
                        begin
                            phase_next = ufc_pkg::PH_PCT;
                        end
                    end
                    else
                    begin
                        step_out.cnt    = 2'd1;
                        step_out.res[0] = ufc_pkg::mk_res(in_byte, 1'b1, 1'b0);
                    end
                end
                ufc_pkg::PH_PCT:
                begin
                    if (hv[4])
                    begin
                        nib_next = hv[3:0];
                        if (in_last)
                        begin
                            step_out.cnt    = 2'd1;
                            step_out.res[0] = ufc_pkg::mk_res({4'h0, hv[3:0]}, 1'b1, 1'b0);
                            phase_next      = ufc_pkg::PH_IDLE;
                        end
                        else
                        begin
                            phase_next = ufc_pkg::PH_DIGIT;
                        end
                    end
                    else
                    begin
                        // bad escape ends the string here
                        step_out.cnt    = 2'd1;
                        step_out.res[0] = ufc_pkg::mk_res(8'h00, 1'b0, 1'b1);
                        se              = 1'b1;
                        phase_next      = in_last ? ufc_pkg::PH_IDLE : ufc_pkg::PH_HALT;
                    end
                end
                ufc_pkg::PH_DIGIT:
                begin
                    step_out.cnt = 2'd1;
                    if (hv[4])
                    begin
                        step_out.res[0] = ufc_pkg::mk_res({nib_reg, hv[3:0]}, 1'b1, 1'b0);
                    end
                    else
                    begin
                        step_out.res[0] = ufc_pkg::mk_res({4'h0, nib_reg}, 1'b1, 1'b0);
                    end
                    phase_next = ufc_pkg::PH_IDLE;
                end
                default:
                begin
                    if (in_last)
                    begin
                        phase_next = ufc_pkg::PH_IDLE;
                    end
                end
            endcase
        end

        // mark the final result of this request
        case (step_out.cnt)
            2'd1:
            begin
                step_out.res[0].run_last   = 1'b1;
                step_out.res[0].string_end = se;
            end
            2'd3:
            begin
                step_out.res[2].run_last   = 1'b1;
                step_out.res[2].string_end = se;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg   <= ufc_pkg::DIR_ENCODE;
            phase_reg <= ufc_pkg::PH_IDLE;
            nib_reg   <= 4'h0;
        end
        else if (cfg_we)
        begin
            dir_reg   <= cfg_data;
            phase_reg <= ufc_pkg::PH_IDLE;
            nib_reg   <= 4'h0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            nib_reg   <= nib_next;
        end
    end

endmodule

[rtl/core/ufc_obuf.sv]
// ufc_obuf: three-entry result buffer, shifts out one result per cycle while out_ready is high
// depends on ufc_pkg

module ufc_obuf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  ufc_pkg::step_out_t  load_data,
    input  logic                out_ready,
    output logic                out_valid,
    output ufc_pkg::res_t       head,
    output logic                can_take,
    output logic [1:0]          fill
);

    ufc_pkg::res_t [2:0] buf_reg, buf_next;
    logic [1:0]          cnt_reg, cnt_next;
    logic                pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign head      = buf_reg[0];
    assign pop       = out_valid && out_ready;
    assign can_take  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);
    assign fill      = cnt_reg;

    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            buf_next = load_data.res;
            cnt_next = load_data.cnt;
        end
        else if (pop)
        begin
            buf_next[0] = buf_reg[1];
            buf_next[1] = buf_reg[2];
            cnt_next    = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

[rtl/core/url_form_codec_top.sv]
// url_form_codec_top: form url codec, encode or decode one byte stream
// depends on ufc_pkg, ufc_in_if, ufc_out_if, ufc_step, ufc_obuf
//
//  channel   dir  payload                                              handshake
//  in_ch     in   in_byte[7:0], in_last                                valid/ready
//  out_ch    out  out_byte[7:0], has_byte, run_last, string_end,       valid/ready
//                 bad_escape
//  cfg       in   cfg_data (direction)                                 cfg_we, no ready
//
// an accepted request is turned into zero to three results in the same cycle and
// loaded into the result buffer; results leave one per cycle from the buffer head while out_ch.ready is high
// how fast requests are taken is set by that output buffer, so an escaped encode
// byte, with its three results, holds the input longest
// in_ch.ready is high while the buffer is empty or about to hand out its last entry
// reset clears direction to encode, decode state to idle and empties the buffer
// a direction write also returns the decode state to idle

module url_form_codec_top (
    input  logic              clk,
    input  logic              rst_n,
    ufc_in_if.sink            in_ch,
    ufc_out_if.source         out_ch,
    input  logic              cfg_we,
    input  logic              cfg_data
);

    ufc_pkg::step_out_t  step_out;
    ufc_pkg::res_t       head;
    logic                in_acc;
    logic                can_take;
    logic [1:0]          fill;

    // request accepted this edge
    assign in_ch.ready = can_take;
    assign in_acc      = in_ch.valid && can_take;

    // per-request logic and decode state
    ufc_step u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (in_acc),
        .in_byte  (in_ch.in_byte),
        .in_last  (in_ch.in_last),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .step_out (step_out)
    );

    // result buffer toward the sink
    ufc_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_acc),
        .load_data (step_out),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .head      (head),
        .can_take  (can_take),
        .fill      (fill)
    );

    assign out_ch.out_byte   = head.out_byte;
    assign out_ch.has_byte   = head.has_byte;
    assign out_ch.run_last   = head.run_last;
    assign out_ch.string_end = head.string_end;
    assign out_ch.bad_escape = head.bad_escape;

    // the end of a string is always the last result of its request
    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.string_end |-> out_ch.run_last)
        else $error("string_end without run_last");

    // a bad escape marker carries no byte and closes the string
    a_bad_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.bad_escape |-> !out_ch.has_byte && out_ch.string_end)
        else $error("malformed bad escape marker");

    // a new request never overwrites results still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> (fill == 2'd0) || ((fill == 2'd1) && out_ch.ready))
        else $error("request accepted over pending results");

    // the buffer never shows a result past its request's last one
    a_run_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.ready && out_ch.run_last && !in_acc |=> !out_ch.valid)
        else $error("result left after run_last");

endmodule

[tb/tb_url_form_codec_top.sv]
// tb_url_form_codec_top: self-checking testbench of the form url codec
// depends on ufc_pkg, ufc_in_if, ufc_out_if and url_form_codec_top

module tb_url_form_codec_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef ufc_pkg::res_t   res_t;
    typedef ufc_pkg::phase_t phase_t;

    localparam logic       DIR_ENCODE = ufc_pkg::DIR_ENCODE;
    localparam logic       DIR_DECODE = ufc_pkg::DIR_DECODE;
    localparam logic [7:0] CH_SPACE   = ufc_pkg::CH_SPACE;
    localparam logic [7:0] CH_PLUS    = ufc_pkg::CH_PLUS;
    localparam logic [7:0] CH_PERCENT = ufc_pkg::CH_PERCENT;

    localparam int CLK_PERIOD  = 12;
    localparam int RESET_TICKS = 12;
    // cycles allowed for the block to go quiet once nothing is expected
    localparam int SETTLE      = 8;
    // long receiver hold-off so the result buffer fills and the input stalls
    localparam int HOLD_CYCLES = 80;
    localparam int N_PHASES    = 6;
    localparam int PHASE_ITEMS = 15;
    // worst case is far below this: ~140 requests, three results each, long stalls
    localparam longint LIMIT_NS = 64'd5_000_000;

    // one directed request; typed rows carry their expected characters,
    // the rest go through the predictor
    typedef struct packed {
        logic        dir;
        logic        rewrite;   // rewrite direction before this request
        logic [7:0]  ch;
        logic        last;
        logic        typed;
        logic [1:0]  cnt;
        logic        bad;       // typed result is the bare bad-escape marker
        logic [23:0] chars;     // typed characters, first one in the top byte
    } stim_row_t;

    localparam int N_DIRECTED = 28;
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        // encode: letters and digits pass, space to plus, the rest escaped
        '{DIR_ENCODE, 1'b0, "A",        1'b0, 1'b1, 2'd1, 1'b0, {"A", 16'h0}},
        '{DIR_ENCODE, 1'b0, "z",        1'b0, 1'b1, 2'd1, 1'b0, {"z", 16'h0}},
        '{DIR_ENCODE, 1'b0, "9",        1'b0, 1'b0, 2'd0, 1'b0, 24'h0},
        '{DIR_ENCODE, 1'b0, CH_SPACE,   1'b0, 1'b1, 2'd1, 1'b0, {CH_PLUS, 16'h0}},
        '{DIR_ENCODE, 1'b0, 8'hFF,      1'b0, 1'b1, 2'd3, 1'b0, "%FF"},
        '{DIR_ENCODE, 1'b0, 8'h80,      1'b0, 1'b1, 2'd3, 1'b0, "%80"},
        '{DIR_ENCODE, 1'b0, 8'h01,      1'b0, 1'b0, 2'd0, 1'b0, 24'h0},
        '{DIR_ENCODE, 1'b0, CH_PLUS,    1'b0, 1'b0, 2'd0, 1'b0, 24'h0},
        // zero byte in encode
        '{DIR_ENCODE, 1'b0, 8'h00,      1'b1, 1'b1, 2'd3, 1'b0, "%00"},
        // decode: plus to space, then a good escape
        '{DIR_DECODE, 1'b0, CH_PLUS,    1'b0, 1'b1, 2'd1, 1'b0, {CH_SPACE, 16'h0}},
        '{DIR_DECODE, 1'b0, CH_PERCENT, 1'b0, 1'b1, 2'd0, 1'b0, 24'h0},
        '{DIR_DECODE, 1'b0, "4",        1'b0, 1'b1, 2'd0, 1'b0, 24'h0},
        '{DIR_DECODE, 1'b0, "1",        1'b0, 1'b1, 2'd1, 1'b0, {"A", 16'h0}},
        // lower-case hex digit
        '{DIR_DECODE, 1'b0, CH_PERCENT, 1'b0, 1'b0, 2'd0, 1'b0, 24'h0},
        '{DIR_DECODE, 1'b0, "6",        1'b0, 1'b0, 2'd0, 1'b0, 24'h0},
        '{DIR_DECODE, 1'b0, "a",        1'b0, 1'b0, 2'd0, 1'b0, 24'h0},
        // second digit not hex: first digit value out, byte dropped
        '{DIR_DECODE, 1'b0, CH_PERCENT, 1'b0, 1'b0, 2'd0, 1'b0, 24'h0},
        '{DIR_DECODE, 1'b0, "F",        1'b0, 1'b0, 2'd0, 1'b0, 24'h0},
        '{DIR_DECODE, 1'b0, "z",        1'b0, 1'b0, 2'd0, 1'b0, 24'h0},
        // string ends right after the percent
        '{DIR_DECODE, 1'b0, CH_PERCENT, 1'b1, 1'b1, 2'd1, 1'b1, 24'h0},
        // non-hex after percent: marker, then the string is dropped up to its end
        '{DIR_DECODE, 1'b0, CH_PERCENT, 1'b0, 1'b1, 2'd0, 1'b0, 24'h0},
        '{DIR_DECODE, 1'b0, "g",        1'b0, 1'b1, 2'd1, 1'b1, 24'h0},
        '{DIR_DECODE, 1'b0, "x",        1'b0, 1'b1, 2'd0, 1'b0, 24'h0},
        '{DIR_DECODE, 1'b0, CH_PERCENT, 1'b1, 1'b1, 2'd0, 1'b0, 24'h0},
        // string ends after percent and one digit
        '{DIR_DECODE, 1'b0, CH_PERCENT, 1'b0, 1'b0, 2'd0, 1'b0, 24'h0},
        '{DIR_DECODE, 1'b0, "7",        1'b1, 1'b0, 2'd0, 1'b0, 24'h0},
        // a direction write mid-escape returns the decoder to idle
        '{DIR_DECODE, 1'b0, CH_PERCENT, 1'b0, 1'b0, 2'd0, 1'b0, 24'h0},
        '{DIR_DECODE, 1'b1, "4",        1'b1, 1'b0, 2'd0, 1'b0, 24'h0}
    };

    localparam logic PHASE_DIR [N_PHASES] = '{DIR_DECODE, DIR_ENCODE, DIR_DECODE,
                                              DIR_DECODE, DIR_ENCODE, DIR_DECODE};

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_data;

    ufc_in_if  in_ch();
    ufc_out_if out_ch();

    url_form_codec_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // predictor state, mirrors the block after reset
    logic       mode_dir = DIR_ENCODE;
    phase_t     dec_phase = ufc_pkg::PH_IDLE;
    logic [3:0] dec_hi = 4'h0;

    res_t       out_chars_due [$];   // predicted results not yet seen
    res_t       step_res [$];        // results of the request just accepted
    logic [7:0] str_q [$];           // string being built for the random part
    bit         failed = 1'b0;
    bit         calm = 1'b0;         // no gaps on either side
    bit         hold_req = 1'b0;     // asks the receiver for a long hold-off

    // ------------------------------------------------------------------
    // character helpers of the predictor
    // ------------------------------------------------------------------

    // value of a hex digit in either case, -1 for anything else
    function automatic int digit_val(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return int'(c) - int'("0");
        end
        if (c >= "A" && c <= "F")
        begin
            return int'(c) - int'("A") + 10;
        end
        if (c >= "a" && c <= "f")
        begin
            return int'(c) - int'("a") + 10;
        end
        return -1;
    endfunction

    function automatic bit is_word_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    // upper-case hex character of one nibble
    function automatic logic [7:0] nib_char(input logic [3:0] n);
        if (n < 4'd10)
        begin
            return "0" + n;
        end
        return "A" + n - 4'd10;
    endfunction

    function automatic res_t out_char(input logic [7:0] c);
        res_t r;
        r = '0;
        r.out_byte = c;
        r.has_byte = 1'b1;
        return r;
    endfunction

    function automatic res_t bad_marker();
        res_t r;
        r = '0;
        r.bad_escape = 1'b1;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // predictor: results of one accepted request, left in step_res
    // ------------------------------------------------------------------
    function automatic void form_codec_step(input logic [7:0] c, input logic last);
        int   v;
        logic closes;
        res_t tail;
        v = digit_val(c);
        closes = last;
        step_res.delete();
        if (mode_dir == DIR_ENCODE)
        begin
            // the decode state is left alone while encoding
            if (is_word_char(c))
            begin
                step_res.push_back(out_char(c));
            end
            else if (c == CH_SPACE)
            begin
                step_res.push_back(out_char(CH_PLUS));
            end
            else
            begin
                step_res.push_back(out_char(CH_PERCENT));
                step_res.push_back(out_char(nib_char(c[7:4])));
                step_res.push_back(out_char(nib_char(c[3:0])));
            end
        end
        else
        begin
            case (dec_phase)
                ufc_pkg::PH_IDLE:
                begin
                    if (c == CH_PLUS)
                    begin
                        step_res.push_back(out_char(CH_SPACE));
                    end
                    else if (c == CH_PERCENT)
                    begin
                        // a percent closing the string counts as a broken escape
                        if (last)
                        begin
                            step_res.push_back(bad_marker());
                        end
                        else
                        begin
                            dec_phase = ufc_pkg::PH_PCT;
                        end
                    end
                    else
                    begin
                        step_res.push_back(out_char(c));
                    end
                end
                ufc_pkg::PH_PCT:
                begin
                    if (v >= 0)
                    begin
                        dec_hi = v[3:0];
                        if (last)
                        begin
                            step_res.push_back(out_char({4'h0, dec_hi}));
                            dec_phase = ufc_pkg::PH_IDLE;
                        end
                        else
                        begin
                            dec_phase = ufc_pkg::PH_DIGIT;
                        end
                    end
                    else
                    begin
                        // broken escape ends the string at once, rest is dropped
                        step_res.push_back(bad_marker());
                        dec_phase = last ? ufc_pkg::PH_IDLE : ufc_pkg::PH_HALT;
                        closes = 1'b1;
                    end
                end
                ufc_pkg::PH_DIGIT:
                begin
                    if (v >= 0)
                    begin
                        step_res.push_back(out_char({dec_hi, v[3:0]}));
                    end
                    else
                    begin
                        step_res.push_back(out_char({4'h0, dec_hi}));
                    end
                    dec_phase = ufc_pkg::PH_IDLE;
                end
                default:
                begin
                    if (last)
                    begin
                        dec_phase = ufc_pkg::PH_IDLE;
                    end
                end
            endcase
        end
        if (step_res.size() > 0)
        begin
            tail = step_res.pop_back();
            tail.run_last = 1'b1;
            tail.string_end = closes;
            step_res.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_hex_char();
        logic [3:0] n;
        logic [7:0] c;
        n = 4'($urandom_range(0, 15));
        c = nib_char(n);
        if (n >= 4'd10 && $urandom_range(0, 1) == 1)
        begin
            c = c + ("a" - "A");
        end
        return c;
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (digit_val(c) >= 0);
        return c;
    endfunction

    // encode strings: a mix of word characters, spaces and any other byte
    function automatic void make_encode_string();
        int         len;
        int         r;
        logic [7:0] c;
        len = $urandom_range(1, 8);
        str_q.delete();
        repeat (len)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                c = nib_char(4'($urandom_range(0, 9)));
                if ($urandom_range(0, 1) == 1)
                begin
                    c = c + 8'd17;
                end
                str_q.push_back(c);
            end
            else if (r < 55)
            begin
                str_q.push_back(CH_SPACE);
            end
            else
            begin
                str_q.push_back(8'($urandom_range(1, 255)));
            end
        end
    endfunction

    // decode strings: well-formed escapes with random content are the commonest token,
    // the rest plain bytes, plus signs and broken or cut-off escapes
    function automatic void make_decode_string();
        int   tokens;
        int   r;
        logic [7:0] c;
        tokens = $urandom_range(1, 4);
        str_q.delete();
        repeat (tokens)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                do
                    c = 8'($urandom_range(1, 255));
                while (c == CH_PERCENT);
                str_q.push_back(c);
            end
            else if (r < 42)
            begin
                str_q.push_back(CH_PLUS);
            end
            else if (r < 82)
            begin
                str_q.push_back(CH_PERCENT);
                str_q.push_back(rand_hex_char());
                str_q.push_back(rand_hex_char());
            end
            else
            begin
                str_q.push_back(CH_PERCENT);
                case ($urandom_range(0, 2))
                    0: str_q.push_back(rand_non_hex());
                    1:
                    begin
                        str_q.push_back(rand_hex_char());
                        str_q.push_back(rand_non_hex());
                    end
                    default: ;
                endcase
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // offer one request, wait for its handshake, then predict it;
    // typed rows push their own expectation instead
    task automatic send_item(input logic [7:0] c, input logic last, input bit typed);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= c;
        in_ch.in_last <= last;
        do
            @(posedge clk);
        while (!(in_ch.valid && in_ch.ready));
        form_codec_step(c, last);
        if (!typed)
        begin
            foreach (step_res[k])
            begin
                out_chars_due.push_back(step_res[k]);
            end
        end
    endtask

    // wait until every predicted result has come out, then let the block settle
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (out_chars_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // direction write; the decode state returns to idle with it
    task automatic set_direction(input logic d);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= d;
        @(posedge clk);
        cfg_we   <= 1'b0;
        mode_dir  = d;
        dec_phase = ufc_pkg::PH_IDLE;
        dec_hi    = 4'h0;
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        stim_row_t row;
        res_t      r;
        int        sent;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_data       = DIR_ENCODE;
        in_ch.valid    = 1'b0;
        in_ch.in_byte  = 8'h00;
        in_ch.in_last  = 1'b0;
        repeat (RESET_TICKS) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, walked row by row; the block starts in encode
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            row = DIRECTED[i];
            if (row.dir != mode_dir || row.rewrite)
            begin
                set_direction(row.dir);
            end
            send_item(row.ch, row.last, row.typed);
            if (row.typed)
            begin
                for (int k = 0; k < row.cnt; k++)
                begin
                    r            = '0;
                    r.out_byte   = row.bad ? 8'h00 : row.chars[23 - 8 * k -: 8];
                    r.has_byte   = !row.bad;
                    r.run_last   = (k == row.cnt - 1);
                    r.string_end = r.run_last && (row.last || row.bad);
                    r.bad_escape = row.bad;
                    out_chars_due.push_back(r);
                end
            end
        end

        // random part: several direction settings, one written twice in a row,
        // two phases without gaps and the second of them with a long receiver hold-off
        for (int p = 0; p < N_PHASES; p++)
        begin
            set_direction(PHASE_DIR[p]);
            calm = (p == 2 || p == 3);
            if (p == 3)
            begin
                hold_req = 1'b1;
            end
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if (mode_dir == DIR_ENCODE)
                begin
                    make_encode_string();
                end
                else
                begin
                    make_decode_string();
                end
                foreach (str_q[k])
                begin
                    send_item(str_q[k], k == str_q.size() - 1, 1'b0);
                end
                sent += str_q.size();
            end
        end
        calm = 1'b0;

        wait_idle();
        if (!failed)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // compare one accepted result with the oldest prediction
    function automatic void check_result();
        res_t due;
        if (out_chars_due.size() == 0)
        begin
            $error("result with nothing predicted: out_byte %h has_byte %b",
                   out_ch.out_byte, out_ch.has_byte);
            failed = 1'b1;
            return;
        end
        due = out_chars_due.pop_front();
        if (out_ch.out_byte !== due.out_byte)
        begin
            $error("out_byte: expected %h, got %h", due.out_byte, out_ch.out_byte);
            failed = 1'b1;
        end
        if (out_ch.has_byte !== due.has_byte)
        begin
            $error("has_byte: expected %b, got %b", due.has_byte, out_ch.has_byte);
            failed = 1'b1;
        end
        if (out_ch.run_last !== due.run_last)
        begin
            $error("run_last: expected %b, got %b", due.run_last, out_ch.run_last);
            failed = 1'b1;
        end
        if (out_ch.string_end !== due.string_end)
        begin
            $error("string_end: expected %b, got %b", due.string_end, out_ch.string_end);
            failed = 1'b1;
        end
        if (out_ch.bad_escape !== due.bad_escape)
        begin
            $error("bad_escape: expected %b, got %b", due.bad_escape, out_ch.bad_escape);
            failed = 1'b1;
        end
    endfunction

    // receiver: runs of ready broken by stalls of random length,
    // plus one long hold-off when asked
    initial
    begin : result_sink
        int run_left;
        int stall_left;
        int hold_left;
        run_left     = 0;
        stall_left   = 0;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                check_result();
            end
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (calm)
            begin
                out_ch.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (run_left > 0)
            begin
                run_left--;
                out_ch.ready <= 1'b1;
            end
            else
            begin
                // new stall first, then a run of ready
                stall_left = pick_gap();
                run_left   = $urandom_range(1, 12);
                if (stall_left > 0)
                begin
                    stall_left--;
                    out_ch.ready <= 1'b0;
                end
                else
                begin
                    run_left--;
                    out_ch.ready <= 1'b1;
                end
            end
        end
    end

    // hard stop if the run hangs
    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/ufc_pkg.sv
rtl/core/ufc_in_if.sv
rtl/core/ufc_out_if.sv
rtl/core/ufc_step.sv
rtl/core/ufc_obuf.sv
rtl/core/url_form_codec_top.sv
tb/tb_url_form_codec_top.sv
